// ===== design/group_bitmap_block_allocator_core_defines.svh =====
// assertion helpers for the block group allocator
`ifndef GROUP_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define GROUP_BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle, held off during reset
`define GBBA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold
`define GBBA_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== design/gbba_pkg.sv =====
`default_nettype none

package gbba_pkg;

	localparam int MODE_W  = 2;
	localparam int BLOCK_W = 18;
	localparam int GIDX_W  = 4;
	localparam int WIDX_W  = 8;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 14;
	localparam int STAT_W  = 2;

	localparam int GC_W      = 5;
	localparam int BPG_W     = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 14;

	localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_WORD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOAD_CNT  = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_GROUPS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_GROUP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_BLK  = 2'd2;

	localparam logic [GC_W-1:0]  NUM_GROUPS_RST     = 5'd16;
	localparam logic [BPG_W-1:0] BITS_PER_GROUP_RST = 14'd8192;
	localparam logic             FIRST_DATA_BLK_RST = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [BLOCK_W-1:0] block_number;
		logic [GIDX_W-1:0]  group_index;
		logic [WIDX_W-1:0]  word_index;
		logic [WORD_W-1:0]  word_value;
		logic [CNT_W-1:0]   free_count_value;
	} in_item_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] allocated_block;
		logic [STAT_W-1:0]  status;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/group_bitmap_block_allocator_core.sv =====
// Block group bitmap allocator.
// in_data (valid/ready) carries one item: allocate, free a block, load a bitmap
// word or load a group free count. Each item gives exactly one out_data item
// (allocated_block, status) on the out valid/ready channel, in order.
// cfg (valid/ready, always ready) writes the group count, blocks per group and
// first data block number by index; write only while no item is in flight.
// After reset the block sweeps both memories to zero, one word a cycle, over all
// MAX_GROUPS*GROUP_BITS/32 bitmap words (4096 by default); in_ready stays low then.
// Bitmaps sit in one single-port-read memory, free counts in a second one,
// both with a registered read; allocate and free update by read, modify, write back.
// Loads and items rejected at once go straight to the response. Free: the block
// number is reduced by bits_per_group, one group step per cycle, until it lies
// in a group; then its bitmap word and free count are updated. Allocate: groups
// are visited in order, empty ones skipped, and bitmap words scanned for a clear bit.
// Only one item is worked on at a time; a new item is taken while the
// previous result still waits in the output register. If the receiver stalls,
// a finished result waits until the output register is free.
`default_nettype none

`include "group_bitmap_block_allocator_core_defines.svh"

module group_bitmap_block_allocator_core #(
	parameter int MAX_GROUPS = 16,
	parameter int GROUP_BITS = 8192
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire gbba_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output gbba_pkg::out_item_t                      out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [gbba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gbba_pkg::CFG_DAT_W-1:0]      cfg_data
);

	localparam int WPG    = GROUP_BITS / 32;
	localparam int DEPTH  = MAX_GROUPS * WPG;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW    = $clog2(MAX_GROUPS + 1);
	localparam int WW     = (WPG > 1) ? $clog2(WPG) : 1;
	localparam int USABLE = WPG * 32;
	localparam int BW     = $clog2(USABLE + 1);
	localparam int LW     = ((BW > gbba_pkg::BPG_W) ? BW : gbba_pkg::BPG_W) + 1;
	localparam int CW     = gbba_pkg::CNT_W;
	localparam int BLW    = gbba_pkg::BLOCK_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_A_CNT  = 3'd2;
	localparam logic [2:0] S_A_WORD = 3'd3;
	localparam logic [2:0] S_F_DIV  = 3'd4;
	localparam logic [2:0] S_F_RMW  = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	// control registers
	logic [2:0]                  state_q, state_n;
	logic [AW-1:0]               clr_q, clr_n;
	logic                        out_valid_q;
	logic [gbba_pkg::GC_W-1:0]   gc_q;
	logic [gbba_pkg::BPG_W-1:0]  bpg_q;
	logic                        fdb_q;

	// working registers
	logic [GW-1:0]               g_q, g_n;
	logic [AW-1:0]               gaddr_q, gaddr_n;
	logic [WW-1:0]               w_q, w_n;
	logic [BLW-1:0]              base_q, base_n;
	logic [BLW-1:0]              rel_q, rel_n;
	logic [AW-1:0]               addr_q, addr_n;
	logic [4:0]                  bit_q, bit_n;
	logic [BLW-1:0]              res_blk_q, res_blk_n;
	logic [gbba_pkg::STAT_W-1:0] res_stat_q, res_stat_n;
	gbba_pkg::out_item_t         out_q;

	// memories
	logic [31:0]                 bm_mem [DEPTH];
	logic [CW-1:0]               cn_mem [MAX_GROUPS];
	logic [31:0]                 bm_rd_q;
	logic [CW-1:0]               cn_rd_q;
	logic                        bm_we, bm_re, cn_we, cn_re;
	logic [AW-1:0]               bm_waddr, bm_raddr;
	logic [31:0]                 bm_wdata;
	logic [GW-1:0]               cn_waddr, cn_raddr;
	logic [CW-1:0]               cn_wdata;

	// derived configuration
	logic [gbba_pkg::BPG_W-1:0]  nb;
	logic [GCW-1:0]              ng;
	logic                        last_group;

	// word scan
	logic [31:0]                 bmask, cand, onehot;
	logic [4:0]                  hit_bit;
	logic                        alloc_hit, more_words;
	logic                        in_acc;
	logic                        grp_ok, word_ok;

	assign nb = (32'(bpg_q) > 32'(USABLE)) ? gbba_pkg::BPG_W'(USABLE) : bpg_q;
	assign ng = (32'(gc_q) > 32'(MAX_GROUPS)) ? GCW'(MAX_GROUPS) : GCW'(gc_q);
	assign last_group = (GCW'(g_q) + GCW'(1)) >= ng;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign grp_ok  = 32'(in_data.group_index) < 32'(MAX_GROUPS);
	assign word_ok = 32'(in_data.word_index) < 32'(WPG);

	// first clear bit of the current word that still lies inside the group
	always_comb begin
		for (int j = 0; j < 32; j++) begin
			bmask[j] = LW'({w_q, 5'(j)}) < LW'(nb);
		end
		cand   = ~bm_rd_q & bmask;
		onehot = cand & (~cand + 32'd1);
		hit_bit = '0;
		for (int j = 0; j < 32; j++) begin
			if (onehot[j]) begin
				hit_bit = hit_bit | 5'(j);
			end
		end
		alloc_hit  = |cand;
		more_words = (LW'({w_q, 5'd31}) + LW'(1)) < LW'(nb);
	end

	always_comb begin
		state_n    = state_q;
		clr_n      = clr_q;
		g_n        = g_q;
		gaddr_n    = gaddr_q;
		w_n        = w_q;
		base_n     = base_q;
		rel_n      = rel_q;
		addr_n     = addr_q;
		bit_n      = bit_q;
		res_blk_n  = res_blk_q;
		res_stat_n = res_stat_q;
		bm_we      = 1'b0;
		bm_waddr   = addr_q;
		bm_wdata   = '0;
		bm_re      = 1'b0;
		bm_raddr   = gaddr_q;
		cn_we      = 1'b0;
		cn_waddr   = g_q;
		cn_wdata   = '0;
		cn_re      = 1'b0;
		cn_raddr   = g_q;

		unique case (state_q)
			S_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_q;
				cn_we    = 32'(clr_q) < 32'(MAX_GROUPS);
				cn_waddr = GW'(clr_q);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_n = S_IDLE;
				end else begin
					clr_n = clr_q + AW'(1);
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					res_blk_n  = '0;
					res_stat_n = gbba_pkg::STATUS_DONE;
					g_n        = '0;
					gaddr_n    = '0;
					base_n     = '0;
					state_n    = S_RESP;
					unique case (in_data.mode)
						gbba_pkg::MODE_ALLOC: begin
							if (ng == '0 || nb == '0) begin
								res_stat_n = gbba_pkg::STATUS_NONE;
							end else begin
								cn_re    = 1'b1;
								cn_raddr = '0;
								state_n  = S_A_CNT;
							end
						end
						gbba_pkg::MODE_FREE: begin
							if (in_data.block_number < BLW'(fdb_q) || nb == '0 || ng == '0) begin
								res_stat_n = gbba_pkg::STATUS_RANGE;
							end else begin
								rel_n   = in_data.block_number - BLW'(fdb_q);
								state_n = S_F_DIV;
							end
						end
						gbba_pkg::MODE_LOAD_WORD: begin
							bm_we    = grp_ok && word_ok;
							bm_waddr = AW'(32'(in_data.group_index) * WPG
								+ 32'(in_data.word_index));
							bm_wdata = in_data.word_value;
						end
						default: begin
							cn_we    = grp_ok;
							cn_waddr = GW'(in_data.group_index);
							cn_wdata = in_data.free_count_value;
						end
					endcase
				end
			end
			S_A_CNT: begin
				if (cn_rd_q == '0) begin
					// skip empty group
					if (last_group) begin
						res_stat_n = gbba_pkg::STATUS_NONE;
						state_n    = S_RESP;
					end else begin
						g_n      = g_q + GW'(1);
						gaddr_n  = gaddr_q + AW'(WPG);
						base_n   = base_q + BLW'(nb);
						cn_re    = 1'b1;
						cn_raddr = g_q + GW'(1);
					end
				end else begin
					w_n      = '0;
					bm_re    = 1'b1;
					bm_raddr = gaddr_q;
					state_n  = S_A_WORD;
				end
			end
			S_A_WORD: begin
				if (alloc_hit) begin
					bm_we      = 1'b1;
					bm_waddr   = gaddr_q + AW'(w_q);
					bm_wdata   = bm_rd_q | onehot;
					cn_we      = 1'b1;
					cn_waddr   = g_q;
					cn_wdata   = cn_rd_q - CW'(1);
					res_blk_n  = base_q + BLW'({w_q, hit_bit}) + BLW'(fdb_q);
					state_n    = S_RESP;
				end else if (more_words) begin
					w_n      = w_q + WW'(1);
					bm_re    = 1'b1;
					bm_raddr = gaddr_q + AW'(w_q) + AW'(1);
				end else if (last_group) begin
					res_stat_n = gbba_pkg::STATUS_NONE;
					state_n    = S_RESP;
				end else begin
					g_n      = g_q + GW'(1);
					gaddr_n  = gaddr_q + AW'(WPG);
					base_n   = base_q + BLW'(nb);
					cn_re    = 1'b1;
					cn_raddr = g_q + GW'(1);
					state_n  = S_A_CNT;
				end
			end
			S_F_DIV: begin
				// one subtract of bits_per_group per cycle finds the group
				if (rel_q < BLW'(nb)) begin
					addr_n   = gaddr_q + AW'(rel_q[gbba_pkg::BPG_W-1:5]);
					bit_n    = rel_q[4:0];
					bm_re    = 1'b1;
					bm_raddr = gaddr_q + AW'(rel_q[gbba_pkg::BPG_W-1:5]);
					cn_re    = 1'b1;
					cn_raddr = g_q;
					state_n  = S_F_RMW;
				end else if (last_group) begin
					res_stat_n = gbba_pkg::STATUS_RANGE;
					state_n    = S_RESP;
				end else begin
					rel_n   = rel_q - BLW'(nb);
					g_n     = g_q + GW'(1);
					gaddr_n = gaddr_q + AW'(WPG);
				end
			end
			S_F_RMW: begin
				bm_we    = 1'b1;
				bm_waddr = addr_q;
				bm_wdata = bm_rd_q & ~(32'd1 << bit_q);
				cn_we    = cn_rd_q < CW'(nb);
				cn_waddr = g_q;
				cn_wdata = cn_rd_q + CW'(1);
				state_n  = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			gc_q        <= gbba_pkg::NUM_GROUPS_RST;
			bpg_q       <= gbba_pkg::BITS_PER_GROUP_RST;
			fdb_q       <= gbba_pkg::FIRST_DATA_BLK_RST;
		end else begin
			state_q <= state_n;
			clr_q   <= clr_n;
			if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					gbba_pkg::REG_NUM_GROUPS:     gc_q  <= cfg_data[gbba_pkg::GC_W-1:0];
					gbba_pkg::REG_BITS_PER_GROUP: bpg_q <= cfg_data[gbba_pkg::BPG_W-1:0];
					gbba_pkg::REG_FIRST_DATA_BLK: fdb_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		g_n_reg: begin
			g_q        <= g_n;
			gaddr_q    <= gaddr_n;
			w_q        <= w_n;
			base_q     <= base_n;
			rel_q      <= rel_n;
			addr_q     <= addr_n;
			bit_q      <= bit_n;
			res_blk_q  <= res_blk_n;
			res_stat_q <= res_stat_n;
		end
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_q.allocated_block <= res_blk_q;
			out_q.status          <= res_stat_q;
		end
	end

	// bitmap store
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rd_q <= bm_mem[bm_raddr];
		end
	end

	// free count store
	always_ff @(posedge clk) begin
		if (cn_we) begin
			cn_mem[cn_waddr] <= cn_wdata;
		end
		if (cn_re) begin
			cn_rd_q <= cn_mem[cn_raddr];
		end
	end

	`GBBA_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !in_ready, "item taken during clear")
	`GBBA_ASSERT_NEVER(a_bm_rw_overlap, bm_re && bm_we, "bitmap read and write in one cycle")
	`GBBA_ASSERT_IMP(a_alloc_cnt_nonzero, (state_q == S_A_WORD) && alloc_hit, cn_rd_q != '0, "alloc from empty group")
	`GBBA_ASSERT_IMP(a_out_from_resp, $rose(out_valid_q), $past(state_q) == S_RESP, "result outside response")
	`GBBA_ASSERT_IMP(a_div_group_range, state_q == S_F_DIV, GCW'(g_q) < ng, "free group past last")

endmodule

`default_nettype wire
